// ----- sv/assert_macros.svh -----
// Assertion macros shared by the stack RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is ignored while reset is high.
`define SWS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stack assertion failed");

// Clocked check that also holds during reset.
`define SWS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("stack assertion failed");

`else

`define SWS_ASSERT(lbl, clk, rst, prop)
`define SWS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- sv/sws_pkg.sv -----
// Types and codes shared by the stack controller, datapath and top level.
package sws_pkg;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   localparam logic [2:0] ST_PUSHED    = 3'd0;
   localparam logic [2:0] ST_POPPED    = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_DUMP      = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;
   localparam logic [2:0] ST_FOUND     = 3'd6;
   localparam logic [2:0] ST_NOTFOUND  = 3'd7;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK
   } state_type;

   typedef enum logic [1:0] {
      DSEL_ZERO,
      DSEL_REQ,
      DSEL_MEM
   } data_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         push;
      logic         pop;
      logic         walk_start;
      logic         walk_step;
      logic         emit;
      logic [2:0]   status;
      data_sel_type data_sel;
      logic         last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       empty;
      logic       full;
      logic       ptr_zero;
      logic       match;
   } dp_stat_type;

endpackage

// ----- sv/sws_datapath.sv -----
// Stack datapath: entry store, entry count, walk pointer and result register.
`include "assert_macros.svh"

module sws_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sws_pkg::dp_cmd_type  cmd,
   input  sws_pkg::req_type     req_item,
   output sws_pkg::dp_stat_type stat,
   output logic                 rsp_strobe,
   output sws_pkg::rsp_type     rsp_item
);
   import sws_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0] mem [DEPTH];

   req_type            req_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff, rd_addr_in;
   logic signed [31:0] rd_data_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_item_ff, rsp_item_in;
   logic [CW-1:0]      top_idx;
   logic               rd_en;

   assign top_idx = count_ff - CW'(1);
   assign rd_en   = cmd.walk_start | cmd.walk_step;

   always_comb begin
      if (cmd.walk_start) begin
         rd_addr_in = top_idx[AW-1:0];
      end else begin
         rd_addr_in = ptr_ff - AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_item_in.status = cmd.status;
      rsp_item_in.last   = cmd.last;
      case (cmd.data_sel)
         DSEL_REQ: rsp_item_in.data = req_ff.value;
         DSEL_MEM: rsp_item_in.data = rd_data_ff;
         default:  rsp_item_in.data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
      if (rd_en) begin
         ptr_ff <= rd_addr_in;
      end
   end

   // Single-port style store: one write for push, one registered read for walks.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[count_ff[AW-1:0]] <= req_ff.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_in];
      end
   end

   assign stat.opcode   = req_ff.opcode;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.match    = (rd_data_ff == req_ff.value);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `SWS_ASSERT(a_push_not_full, clock, reset, cmd.push |-> !stat.full)
   `SWS_ASSERT(a_pop_not_empty, clock, reset, cmd.pop |-> !stat.empty)
   `SWS_ASSERT(a_dump_runs_on, clock, reset, (rsp_strobe_ff && !rsp_item_ff.last) |=> rsp_strobe_ff)
   `SWS_ASSERT_ALWAYS(a_no_strobe_after_reset, clock, reset |=> !rsp_strobe_ff)

endmodule

// ----- sv/sws_ctrl.sv -----
// Stack controller: sequences one item at a time and drives the datapath.
`include "assert_macros.svh"

module sws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sws_pkg::dp_stat_type stat,
   output sws_pkg::dp_cmd_type  cmd
);
   import sws_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((stat.opcode == OP_DUMP || stat.opcode == OP_SEARCH) && !stat.empty) begin
               state_in = S_WALK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.ptr_zero || (stat.opcode == OP_SEARCH && stat.match)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.data_sel = DSEL_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_EXEC: begin
            unique case (stat.opcode)
               OP_PUSH: begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  if (stat.full) begin
                     cmd.status = ST_OVERFLOW;
                  end else begin
                     cmd.push     = 1'b1;
                     cmd.status   = ST_PUSHED;
                     cmd.data_sel = DSEL_REQ;
                  end
               end
               OP_POP: begin
                  cmd.emit   = 1'b1;
                  cmd.last   = 1'b1;
                  cmd.pop    = !stat.empty;
                  cmd.status = stat.empty ? ST_UNDERFLOW : ST_POPPED;
               end
               OP_DUMP: begin
                  if (stat.empty) begin
                     cmd.emit   = 1'b1;
                     cmd.last   = 1'b1;
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.walk_start = 1'b1;
                  end
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.emit   = 1'b1;
                     cmd.last   = 1'b1;
                     cmd.status = ST_NOTFOUND;
                  end else begin
                     cmd.walk_start = 1'b1;
                  end
               end
               default: cmd = '0;
            endcase
         end
         S_WALK: begin
            // The read data in the datapath belongs to the entry at the walk pointer.
            if (stat.opcode == OP_DUMP) begin
               cmd.emit      = 1'b1;
               cmd.status    = ST_DUMP;
               cmd.data_sel  = DSEL_MEM;
               cmd.last      = stat.ptr_zero;
               cmd.walk_step = !stat.ptr_zero;
            end else if (stat.match) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.status = ST_FOUND;
            end else if (stat.ptr_zero) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.status = ST_NOTFOUND;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `SWS_ASSERT(a_exec_after_accept, clock, reset, (start && !busy) |=> (state_ff == S_EXEC))
   `SWS_ASSERT(a_last_frees, clock, reset, (cmd.emit && cmd.last) |=> !busy)
   `SWS_ASSERT(a_one_move, clock, reset, $countones({cmd.push, cmd.pop, cmd.walk_start, cmd.walk_step}) <= 1)

endmodule

// ----- sv/stack_with_search.sv -----
// Stack top level. An item is taken, executed next cycle, and its results follow one a cycle.
// Push and pop: busy only in the execute state, whose result is registered onto rsp_strobe.
// Dump and search: one store read per cycle; busy covers the execute state and a walk step per entry read.
// Dump results strobe on consecutive cycles, top entry first; the receiver cannot stall.
// Synchronous reset empties the stack and idles the block; store contents are left as they are.
module stack_with_search #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sws_pkg::req_type req_item,
   output logic             rsp_strobe,
   output sws_pkg::rsp_type rsp_item
);
   import sws_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sws_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sws_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
